// File: hdl/bba_pkg.sv
// Shared types, constants and helper functions for the bitmap block allocator.
// Used by every file of the allocator but bba_ram; depends on nothing else.
package bba_pkg;

    localparam int MAX_BLOCKS_DEF = 4096;
    localparam int WORD_W         = 64;
    localparam int LOG_W          = 6;
    localparam int CFG_W          = 13;
    localparam int ID_W           = 12;
    localparam int ST_W           = 2;
    localparam int CFG_IDX_W      = 1;

    localparam logic [ST_W-1:0] ST_OK      = 2'd0;
    localparam logic [ST_W-1:0] ST_NOSPACE = 2'd1;
    localparam logic [ST_W-1:0] ST_RANGE   = 2'd2;

    localparam logic FUNC_ALLOC = 1'b0;
    localparam logic FUNC_FREE  = 1'b1;

    localparam logic [CFG_IDX_W-1:0] CFG_TOTAL_BLOCKS = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_FIRST_DATA   = 1'b1;

    localparam logic [CFG_W-1:0] TOTAL_BLOCKS_RST = 13'd4096;
    localparam logic [CFG_W-1:0] FIRST_DATA_RST   = 13'd0;

    typedef struct packed {
        logic             is_first;
        logic             is_last;
        logic [LOG_W-1:0] start_bit;
        logic [LOG_W-1:0] end_bit;
    } scan_bounds_t;

    typedef struct packed {
        logic             found;
        logic [LOG_W-1:0] bit_idx;
    } scan_result_t;

    function automatic scan_result_t lowest_set(input logic [WORD_W-1:0] vec);
        logic [WORD_W-1:0] iso;
        scan_result_t      res;
        iso = vec & (~vec + WORD_W'(1));
        res.found   = |vec;
        res.bit_idx = '0;
        for (int i = 0; i < WORD_W; i++) begin
            if (iso[i]) begin
                res.bit_idx = res.bit_idx | LOG_W'(i);
            end
        end
        return res;
    endfunction

endpackage

// File: hdl/bba_ram.sv
// Generic single-port synchronous RAM with a registered read.
// Stand-alone; used for the allocator's used-block map.
module bba_ram #(
    parameter int WIDTH = 64,
    parameter int DEPTH = 64
) (
    input  logic                                  clk,
    input  logic                                  en,
    input  logic                                  we,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] addr,
    input  logic [WIDTH-1:0]                      wdata,
    output logic [WIDTH-1:0]                      rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            if (we)
            begin
                mem[addr] <= wdata;
            end
            else
            begin
                rdata <= mem[addr];
            end
        end
    end

endmodule

// File: hdl/bba_word_scan.sv
// Masks one map word to the searchable block range and finds its lowest free block.
// Depends on bba_pkg.
module bba_word_scan
    import bba_pkg::*;
(
    input  logic [WORD_W-1:0] word,
    input  scan_bounds_t      bounds,
    output scan_result_t      result
);

    logic [WORD_W-1:0] lo_mask;
    logic [WORD_W-1:0] hi_mask;

    always_comb
    begin
        lo_mask = bounds.is_first ? ({WORD_W{1'b1}} << bounds.start_bit) : {WORD_W{1'b1}};
        hi_mask = bounds.is_last
                ? ({WORD_W{1'b1}} >> (LOG_W'(WORD_W - 1) - bounds.end_bit))
                : {WORD_W{1'b1}};
        result  = lowest_set(~word & lo_mask & hi_mask);
    end

endmodule

// File: hdl/bitmap_block_allocator.sv
// Bitmap block allocator: one used bit per block, kept in a single-port RAM of 64-bit words.
// An allocate scans the map one word per cycle through the single RAM port, from the word that
// holds first_data_block up to the word holding the lowest free block (or the last valid block),
// and sets that block's bit. A free reads the word, modifies it and writes it back; a free out
// of range or an allocate with no searchable range goes straight to its result without using
// the map. One item is in work at a time, and the next item is taken while the previous result
// waits in the output register. After reset the map is cleared one word per cycle while
// in_ready is low; configuration writes must be made only while the block is idle, which the
// block itself does not enforce.
module bitmap_block_allocator
    import bba_pkg::*;
#(
    parameter int MAX_BLOCKS = MAX_BLOCKS_DEF
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 cfg_we,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [CFG_W-1:0]     cfg_data,
    input  logic                 in_valid,
    output logic                 in_ready,
    input  logic                 func,
    input  logic [ID_W-1:0]      block_id,
    output logic                 out_valid,
    input  logic                 out_ready,
    output logic [ST_W-1:0]      status,
    output logic [ID_W-1:0]      granted_block
);

    localparam int DEPTH  = (MAX_BLOCKS + WORD_W - 1) / WORD_W;
    localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int LIM_W  = ($clog2(MAX_BLOCKS) + 1 > CFG_W) ? $clog2(MAX_BLOCKS) + 1 : CFG_W;
    localparam int WIDE_W = (ADDR_W + LOG_W > LIM_W) ? ADDR_W + LOG_W : LIM_W;

    typedef enum logic [4:0] {
        S_CLEAR = 5'b00001,
        S_IDLE  = 5'b00010,
        S_SCAN  = 5'b00100,
        S_FREE  = 5'b01000,
        S_DONE  = 5'b10000
    } state_t;

    state_t            state_reg, state_next;
    logic [CFG_W-1:0]  total_reg, first_reg;
    logic [ADDR_W-1:0] clr_reg, clr_next;
    logic [ADDR_W-1:0] cur_reg, cur_next;
    logic [LOG_W-1:0]  bit_reg, bit_next;
    logic [ST_W-1:0]   res_status_reg, res_status_next;
    logic [ID_W-1:0]   res_grant_reg, res_grant_next;
    logic              out_valid_reg, out_valid_next;
    logic [ST_W-1:0]   out_status_reg, out_status_next;
    logic [ID_W-1:0]   out_grant_reg, out_grant_next;

    logic [WIDE_W-1:0] limit_w, first_w, id_w, last_w, grant_w;
    logic [ADDR_W-1:0] start_word, last_word, id_word;
    logic              alloc_empty, free_bad, load_out;

    logic              ram_en, ram_we;
    logic [ADDR_W-1:0] ram_addr;
    logic [WORD_W-1:0] ram_wdata, ram_rdata;

    scan_bounds_t      bounds;
    scan_result_t      scan;

    bba_ram #(
        .WIDTH (WORD_W),
        .DEPTH (DEPTH)
    ) u_map (
        .clk   (clk),
        .en    (ram_en),
        .we    (ram_we),
        .addr  (ram_addr),
        .wdata (ram_wdata),
        .rdata (ram_rdata)
    );

    bba_word_scan u_scan (
        .word   (ram_rdata),
        .bounds (bounds),
        .result (scan)
    );

    always_comb
    begin
        limit_w     = (WIDE_W'(total_reg) > WIDE_W'(MAX_BLOCKS))
                    ? WIDE_W'(MAX_BLOCKS) : WIDE_W'(total_reg);
        first_w     = WIDE_W'(first_reg);
        id_w        = WIDE_W'(block_id);
        last_w      = limit_w - WIDE_W'(1);
        alloc_empty = first_w >= limit_w;
        free_bad    = id_w >= limit_w;
        start_word  = first_w[LOG_W +: ADDR_W];
        last_word   = last_w[LOG_W +: ADDR_W];
        id_word     = id_w[LOG_W +: ADDR_W];
        grant_w     = WIDE_W'({cur_reg, scan.bit_idx});

        bounds.is_first  = cur_reg == start_word;
        bounds.is_last   = cur_reg == last_word;
        bounds.start_bit = first_w[LOG_W-1:0];
        bounds.end_bit   = last_w[LOG_W-1:0];
    end

    always_comb
    begin
        state_next      = state_reg;
        clr_next        = clr_reg;
        cur_next        = cur_reg;
        bit_next        = bit_reg;
        res_status_next = res_status_reg;
        res_grant_next  = res_grant_reg;
        ram_en          = 1'b0;
        ram_we          = 1'b0;
        ram_addr        = cur_reg;
        ram_wdata       = '0;
        load_out        = 1'b0;

        unique case (state_reg)
            S_CLEAR:
            begin
                ram_en   = 1'b1;
                ram_we   = 1'b1;
                ram_addr = clr_reg;
                clr_next = clr_reg + ADDR_W'(1);
                if (clr_reg == ADDR_W'(DEPTH - 1))
                begin
                    state_next = S_IDLE;
                end
            end
            S_IDLE:
            begin
                res_grant_next = '0;
                if (in_valid)
                begin
                    if (func == FUNC_ALLOC)
                    begin
                        if (alloc_empty)
                        begin
                            res_status_next = ST_NOSPACE;
                            state_next      = S_DONE;
                        end
                        else
                        begin
                            ram_en     = 1'b1;
                            ram_addr   = start_word;
                            cur_next   = start_word;
                            state_next = S_SCAN;
                        end
                    end
                    else
                    begin
                        if (free_bad)
                        begin
                            res_status_next = ST_RANGE;
                            state_next      = S_DONE;
                        end
                        else
                        begin
                            ram_en     = 1'b1;
                            ram_addr   = id_word;
                            cur_next   = id_word;
                            bit_next   = id_w[LOG_W-1:0];
                            state_next = S_FREE;
                        end
                    end
                end
            end
            S_SCAN:
            begin
                if (scan.found)
                begin
                    ram_en          = 1'b1;
                    ram_we          = 1'b1;
                    ram_wdata       = ram_rdata | (WORD_W'(1) << scan.bit_idx);
                    res_status_next = ST_OK;
                    res_grant_next  = grant_w[ID_W-1:0];
                    state_next      = S_DONE;
                end
                else if (bounds.is_last)
                begin
                    res_status_next = ST_NOSPACE;
                    state_next      = S_DONE;
                end
                else
                begin
                    ram_en   = 1'b1;
                    ram_addr = cur_reg + ADDR_W'(1);
                    cur_next = cur_reg + ADDR_W'(1);
                end
            end
            S_FREE:
            begin
                ram_en          = 1'b1;
                ram_we          = 1'b1;
                ram_wdata       = ram_rdata & ~(WORD_W'(1) << bit_reg);
                res_status_next = ST_OK;
                state_next      = S_DONE;
            end
            S_DONE:
            begin
                if (!out_valid_reg || out_ready)
                begin
                    load_out   = 1'b1;
                    state_next = S_IDLE;
                end
            end
        endcase
    end

    always_comb
    begin
        out_valid_next  = out_valid_reg;
        out_status_next = out_status_reg;
        out_grant_next  = out_grant_reg;
        if (load_out)
        begin
            out_valid_next  = 1'b1;
            out_status_next = res_status_reg;
            out_grant_next  = res_grant_reg;
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_CLEAR;
            clr_reg       <= '0;
            out_valid_reg <= 1'b0;
            total_reg     <= TOTAL_BLOCKS_RST;
            first_reg     <= FIRST_DATA_RST;
        end
        else
        begin
            state_reg     <= state_next;
            clr_reg       <= clr_next;
            out_valid_reg <= out_valid_next;
            if (cfg_we)
            begin
                unique case (cfg_index)
                    CFG_TOTAL_BLOCKS: total_reg <= cfg_data;
                    CFG_FIRST_DATA:   first_reg <= cfg_data;
                endcase
            end
        end
    end

    always_ff @(posedge clk)
    begin
        cur_reg        <= cur_next;
        bit_reg        <= bit_next;
        res_status_reg <= res_status_next;
        res_grant_reg  <= res_grant_next;
        out_status_reg <= out_status_next;
        out_grant_reg  <= out_grant_next;
    end

    assign in_ready      = state_reg == S_IDLE;
    assign out_valid     = out_valid_reg;
    assign status        = out_status_reg;
    assign granted_block = out_grant_reg;

endmodule

// File: hdl/bba_checker.sv
// Port-level assertions for the bitmap block allocator, bound to its top level.
// Depends on bba_pkg and on the port names of bitmap_block_allocator.
module bba_checker
    import bba_pkg::*;
(
    input logic            clk,
    input logic            rst_n,
    input logic            in_valid,
    input logic            in_ready,
    input logic            out_valid,
    input logic            out_ready,
    input logic [ST_W-1:0] status,
    input logic [ID_W-1:0] granted_block
);

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(status) && $stable(granted_block))
        else $error("Stalled result changed or dropped.");

    a_status_code: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> status == ST_OK || status == ST_NOSPACE || status == ST_RANGE)
        else $error("Result carries an undefined status.");

    a_grant_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && status != ST_OK |-> granted_block == '0)
        else $error("Failed request carries a nonzero block number.");

    a_one_item: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready |=> !in_ready)
        else $error("A second item was taken while one is in work.");

endmodule

bind bitmap_block_allocator bba_checker u_bba_checker (.*);

// File: dv/bitmap_block_allocator_tb.sv
// Testbench for bitmap_block_allocator: directed and random allocate and free requests,
// checked against an internal model of the used map under several disk geometries.
// Depends on bba_pkg and the bitmap_block_allocator RTL.
module bitmap_block_allocator_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import bba_pkg::*;

    typedef struct packed {
        logic [ST_W-1:0] status;
        logic [ID_W-1:0] granted;
    } grant_t;

    logic                 clk;
    logic                 rst_n;
    logic                 cfg_we;
    logic [CFG_IDX_W-1:0] cfg_index;
    logic [CFG_W-1:0]     cfg_data;
    logic                 in_valid;
    logic                 in_ready;
    logic                 func;
    logic [ID_W-1:0]      block_id;
    logic                 out_valid;
    logic                 out_ready;
    logic [ST_W-1:0]      status;
    logic [ID_W-1:0]      granted_block;

    logic             block_used [MAX_BLOCKS_DEF];
    logic [CFG_W-1:0] total_cfg;
    logic [CFG_W-1:0] first_cfg;
    grant_t           pending_grants[$];
    int               mismatch_count;
    bit               tx_idle;
    bit               rx_idle;
    int               rx_hold;
    int               rx_wait;

    bitmap_block_allocator dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_we        (cfg_we),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data),
        .in_valid      (in_valid),
        .in_ready      (in_ready),
        .func          (func),
        .block_id      (block_id),
        .out_valid     (out_valid),
        .out_ready     (out_ready),
        .status        (status),
        .granted_block (granted_block)
    );

    initial
    begin
        clk = 1'b0;
        forever #1 clk = ~clk;
    end

    initial
    begin
        #2_000_000;
        $display("bitmap_block_allocator verification failed");
        $finish;
    end

    // Applies one request to the model map and returns the result it must produce.
    function automatic grant_t model_request(input logic f, input logic [ID_W-1:0] id);
        int     limit;
        int     b;
        bit     found;
        grant_t r;
        limit = (int'(total_cfg) > MAX_BLOCKS_DEF) ? MAX_BLOCKS_DEF : int'(total_cfg);
        r.status = ST_NOSPACE;
        r.granted = '0;
        found = 1'b0;
        if (f == FUNC_ALLOC)
        begin
            for (b = int'(first_cfg); b < limit && !found; b++)
            begin
                if (!block_used[b])
                begin
                    block_used[b] = 1'b1;
                    r.status = ST_OK;
                    r.granted = ID_W'(b);
                    found = 1'b1;
                end
            end
        end
        else if (int'(id) >= limit)
        begin
            r.status = ST_RANGE;
        end
        else
        begin
            block_used[id] = 1'b0;
            r.status = ST_OK;
        end
        return r;
    endfunction

    function automatic void note_mismatch(input string what, input int exp_val,
                                          input int act_val);
        mismatch_count++;
        if (mismatch_count <= 10)
            $display("%0t: %s mismatch: expected %0d, got %0d", $realtime, what, exp_val,
                     act_val);
    endfunction

    function automatic void rx_wait_draw();
        rx_wait = rx_idle ? $urandom_range(0, 15) : 0;
    endfunction

    task automatic send_request(input logic f, input logic [ID_W-1:0] id);
        int gap;
        gap = tx_idle ? $urandom_range(0, 15) : 0;
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid <= 1'b1;
        func <= f;
        block_id <= id;
        do @(posedge clk); while (!in_ready);
        pending_grants = {pending_grants, model_request(f, id)};
    endtask

    task automatic await_drain();
        in_valid <= 1'b0;
        do @(posedge clk); while (pending_grants.size() != 0);
        repeat (4) @(posedge clk);
    endtask

    task automatic set_geometry(input logic [CFG_W-1:0] total, input logic [CFG_W-1:0] first);
        await_drain();
        cfg_we <= 1'b1;
        cfg_index <= CFG_TOTAL_BLOCKS;
        cfg_data <= total;
        @(posedge clk);
        cfg_index <= CFG_FIRST_DATA;
        cfg_data <= first;
        @(posedge clk);
        cfg_we <= 1'b0;
        total_cfg = total;
        first_cfg = first;
        @(posedge clk);
    endtask

    task automatic test_default_geometry();
        send_request(FUNC_ALLOC, '0);
        send_request(FUNC_ALLOC, 12'hFFF);
        send_request(FUNC_ALLOC, '0);
        send_request(FUNC_FREE, 12'd1);
        send_request(FUNC_ALLOC, '0);
        send_request(FUNC_FREE, 12'hFFF);
        send_request(FUNC_FREE, 12'd0);
    endtask

    task automatic test_zero_blocks();
        set_geometry(13'd0, 13'd0);
        send_request(FUNC_ALLOC, '0);
        send_request(FUNC_FREE, 12'd0);
        send_request(FUNC_FREE, 12'hFFF);
    endtask

    task automatic test_start_past_limit();
        set_geometry(13'd16, 13'd16);
        send_request(FUNC_ALLOC, '0);
        set_geometry(13'd16, 13'h1FFF);
        send_request(FUNC_ALLOC, '0);
        send_request(FUNC_FREE, 12'd15);
        send_request(FUNC_FREE, 12'd16);
    endtask

    task automatic test_saturated_count();
        set_geometry(13'h1FFF, 13'd4090);
        repeat (7) send_request(FUNC_ALLOC, '0);
        send_request(FUNC_FREE, 12'hFFF);
        send_request(FUNC_ALLOC, '0);
    endtask

    task automatic test_random_small_maps();
        logic [CFG_W-1:0] total;
        logic [CFG_W-1:0] first;
        int               top;
        for (int phase = 0; phase < 15; phase++)
        begin
            total = CFG_W'($urandom_range(1, 96));
            if ($urandom_range(0, 7) == 0)
                first = CFG_W'($urandom_range(0, 8191));
            else
                first = CFG_W'($urandom_range(0, int'(total) / 2));
            set_geometry(total, first);
            tx_idle = ($urandom_range(0, 3) != 0);
            rx_idle = ($urandom_range(0, 3) != 0);
            top = int'(total) + 3;
            for (int n = 0; n < 60; n++)
            begin
                if ($urandom_range(0, 99) < 55)
                    send_request(FUNC_ALLOC, ID_W'($urandom_range(0, 4095)));
                else if ($urandom_range(0, 7) == 0)
                    send_request(FUNC_FREE, ID_W'($urandom_range(0, 4095)));
                else
                    send_request(FUNC_FREE, ID_W'($urandom_range(0, top)));
            end
        end
        tx_idle = 1'b1;
        rx_idle = 1'b1;
    endtask

    task automatic test_random_large_maps();
        logic [CFG_W-1:0] total;
        logic [CFG_W-1:0] first;
        for (int phase = 0; phase < 5; phase++)
        begin
            case ($urandom_range(0, 3))
                0: total = CFG_W'(4096);
                1: total = CFG_W'(8191);
                2: total = CFG_W'($urandom_range(1, 8191));
                default: total = CFG_W'($urandom_range(4000, 4096));
            endcase
            if ($urandom_range(0, 1) == 0)
                first = CFG_W'($urandom_range(0, 255));
            else
                first = CFG_W'($urandom_range(3900, 4100));
            set_geometry(total, first);
            for (int n = 0; n < 80; n++)
            begin
                if ($urandom_range(0, 99) < 60)
                    send_request(FUNC_ALLOC, ID_W'($urandom_range(0, 4095)));
                else
                    send_request(FUNC_FREE, ID_W'($urandom_range(0, 4095)));
            end
        end
    endtask

    task automatic test_back_to_back();
        set_geometry(13'd40, 13'd5);
        tx_idle = 1'b0;
        rx_idle = 1'b0;
        for (int n = 0; n < 250; n++)
        begin
            if ($urandom_range(0, 1) == 0)
                send_request(FUNC_ALLOC, ID_W'($urandom_range(0, 4095)));
            else
                send_request(FUNC_FREE, ID_W'($urandom_range(0, 47)));
        end
        tx_idle = 1'b1;
        rx_idle = 1'b1;
    endtask

    task automatic test_output_stall();
        set_geometry(13'd64, 13'd0);
        tx_idle = 1'b0;
        rx_hold = 300;
        for (int n = 0; n < 40; n++)
            send_request($urandom_range(0, 2) == 0 ? FUNC_FREE : FUNC_ALLOC,
                         ID_W'($urandom_range(0, 70)));
        tx_idle = 1'b1;
    endtask

    task automatic test_sender_pause();
        for (int burst = 0; burst < 3; burst++)
        begin
            for (int n = 0; n < 35; n++)
                send_request($urandom_range(0, 1) == 0 ? FUNC_FREE : FUNC_ALLOC,
                             ID_W'($urandom_range(0, 70)));
            await_drain();
        end
    endtask

    initial
    begin
        out_ready <= 1'b0;
        forever
        begin
            @(posedge clk);
            if (out_valid && out_ready)
                rx_wait_draw();
            if (rx_hold > 0)
            begin
                rx_hold--;
                out_ready <= 1'b0;
            end
            else if (rx_wait > 0)
            begin
                rx_wait--;
                out_ready <= 1'b0;
            end
            else
            begin
                out_ready <= 1'b1;
            end
        end
    end

    initial
    begin
        grant_t want;
        forever
        begin
            @(posedge clk);
            if (rst_n && out_valid && out_ready)
            begin
                if (pending_grants.size() == 0)
                begin
                    note_mismatch("unexpected result, status", -1, int'(status));
                end
                else
                begin
                    want = pending_grants.pop_front();
                    if (status !== want.status)
                        note_mismatch("status", int'(want.status), int'(status));
                    if (granted_block !== want.granted)
                        note_mismatch("granted_block", int'(want.granted),
                                      int'(granted_block));
                end
            end
        end
    end

    initial
    begin
        rst_n <= 1'b0;
        cfg_we <= 1'b0;
        cfg_index <= CFG_TOTAL_BLOCKS;
        cfg_data <= '0;
        in_valid <= 1'b0;
        func <= FUNC_ALLOC;
        block_id <= '0;
        foreach (block_used[i])
            block_used[i] = 1'b0;
        total_cfg = TOTAL_BLOCKS_RST;
        first_cfg = FIRST_DATA_RST;
        mismatch_count = 0;
        tx_idle = 1'b1;
        rx_idle = 1'b1;
        rx_hold = 0;
        rx_wait = 0;
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        do @(posedge clk); while (!in_ready);

        test_default_geometry();
        test_zero_blocks();
        test_start_past_limit();
        test_saturated_count();
        test_random_small_maps();
        test_random_large_maps();
        test_back_to_back();
        test_output_stall();
        test_sender_pause();

        await_drain();
        repeat (80) @(posedge clk);
        if (mismatch_count == 0 && pending_grants.size() == 0)
            $display("bitmap_block_allocator verification clean");
        else
            $display("bitmap_block_allocator verification failed");
        $finish;
    end

endmodule

// File: bitmap_block_allocator.f
hdl/bba_pkg.sv
hdl/bba_ram.sv
hdl/bba_word_scan.sv
hdl/bitmap_block_allocator.sv
hdl/bba_checker.sv
dv/bitmap_block_allocator_tb.sv
